// ===== rtl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared sizes and controller/datapath interface types for the priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 16;
  localparam int PRI_W    = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int OCNT_W   = 5;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture a new result this cycle
    logic push;       // insert the input entry
    logic pop;        // remove the head entry
    logic drop;       // push refused, queue full
    logic pop_empty;  // pop found nothing
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } status_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// handshake controller: accepts items, decodes push/pop and holds the result
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic             kind,
  output logic             result_valid,
  input  logic             result_stall,
  input  spq_pkg::status_t status,
  output spq_pkg::cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  // the result register frees up in the same cycle it is taken
  assign item_stall   = (state == ST_HOLD) && result_stall;
  assign accept       = item_valid && !item_stall;
  assign result_valid = (state == ST_HOLD);

  always_comb begin
    cmd.load      = accept;
    cmd.push      = accept && !kind && !status.full;
    cmd.drop      = accept && !kind && status.full;
    cmd.pop       = accept && kind && !status.empty;
    cmd.pop_empty = accept && kind && status.empty;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) state_next = ST_HOLD;
        else if (!result_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/spq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// sorted row of entry cells with parallel compare, plus the result register
// ----------------------------------------------------------------------------
module spq_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  spq_pkg::cmd_t                   cmd,
  output spq_pkg::status_t                status,
  input  logic [spq_pkg::VAL_W-1:0]       item_value,
  input  logic [spq_pkg::PRI_W-1:0]       item_priority,
  output logic [spq_pkg::VAL_W-1:0]       popped_value,
  output logic [spq_pkg::PRI_W-1:0]       popped_priority,
  output logic                            popped_valid,
  output logic                            pop_on_empty,
  output logic                            push_dropped,
  output logic [spq_pkg::VAL_W-1:0]       head_value,
  output logic [spq_pkg::PRI_W-1:0]       head_priority,
  output logic                            queue_empty,
  output logic [spq_pkg::OCNT_W-1:0]      stored_count
);

  logic [spq_pkg::VAL_W-1:0] val_q    [spq_pkg::CAPACITY];
  logic [spq_pkg::PRI_W-1:0] pri_q    [spq_pkg::CAPACITY];
  logic [spq_pkg::VAL_W-1:0] val_next [spq_pkg::CAPACITY];
  logic [spq_pkg::PRI_W-1:0] pri_next [spq_pkg::CAPACITY];
  logic [spq_pkg::CAPACITY-1:0] keep;  // cell stays ahead of the new entry
  logic [spq_pkg::CNT_W-1:0] count;
  logic [spq_pkg::CNT_W-1:0] count_next;

  assign status.full  = (count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign status.empty = (count == '0);

  // keep is a prefix mask since the row is sorted, highest first
  always_comb begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      keep[i] = (spq_pkg::CNT_W'(i) < count) && (pri_q[i] >= item_priority);
    end
  end

  always_comb begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      val_next[i] = val_q[i];
      pri_next[i] = pri_q[i];
      if (cmd.push) begin
        if (keep[i]) begin
          val_next[i] = val_q[i];
          pri_next[i] = pri_q[i];
        end else if (i == 0) begin
          val_next[i] = item_value;
          pri_next[i] = item_priority;
        end else if (keep[i-1]) begin
          val_next[i] = item_value;
          pri_next[i] = item_priority;
        end else begin
          val_next[i] = val_q[i-1];
          pri_next[i] = pri_q[i-1];
        end
      end else if (cmd.pop) begin
        if (i < spq_pkg::CAPACITY - 1) begin
          val_next[i] = val_q[i+1];
          pri_next[i] = pri_q[i+1];
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.push) count_next = count + 1'b1;
    else if (cmd.pop) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
      val_q[i] <= val_next[i];
      pri_q[i] <= pri_next[i];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      popped_value    <= cmd.pop ? val_q[0] : '0;
      popped_priority <= cmd.pop ? pri_q[0] : '0;
      popped_valid    <= cmd.pop;
      pop_on_empty    <= cmd.pop_empty;
      push_dropped    <= cmd.drop;
      head_value      <= (count_next != '0) ? val_next[0] : '0;
      head_priority   <= (count_next != '0) ? pri_next[0] : '0;
      queue_empty     <= (count_next == '0);
      stored_count    <= spq_pkg::OCNT_W'(count_next);
    end
  end

endmodule

// ===== rtl/stable_priority_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue, highest priority first, arrival order among equals
// ----------------------------------------------------------------------------
// Each transfer on the item channel is a push (kind 0) or a pop (kind 1) and
// yields exactly one transfer on the result channel, from the result
// register it loads. The entries sit in a sorted row of cells, every
// cell compares its priority with the incoming one at once, and every cell
// past the insert/pop point shifts by one. A new item is taken whenever the
// result register is empty or being taken, so the block sustains one item
// per cycle unless the result side stalls. A push to a full queue leaves the
// contents alone and sets push_dropped; a pop on an empty queue sets
// pop_on_empty. Each result also shows the head, the empty flag and the
// entry count after the step. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module stable_priority_queue (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          kind,
  input  logic [spq_pkg::VAL_W-1:0]     item_value,
  input  logic [spq_pkg::PRI_W-1:0]     item_priority,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [spq_pkg::VAL_W-1:0]     popped_value,
  output logic [spq_pkg::PRI_W-1:0]     popped_priority,
  output logic                          popped_valid,
  output logic                          pop_on_empty,
  output logic                          push_dropped,
  output logic [spq_pkg::VAL_W-1:0]     head_value,
  output logic [spq_pkg::PRI_W-1:0]     head_priority,
  output logic                          queue_empty,
  output logic [spq_pkg::OCNT_W-1:0]    stored_count
);

  // command and status between controller and cell row
  spq_pkg::cmd_t    cmd;
  spq_pkg::status_t status;

  // handshake and push/pop decode
  spq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // sorted cell row and result register
  spq_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .item_value      (item_value),
    .item_priority   (item_priority),
    .popped_value    (popped_value),
    .popped_priority (popped_priority),
    .popped_valid    (popped_valid),
    .pop_on_empty    (pop_on_empty),
    .push_dropped    (push_dropped),
    .head_value      (head_value),
    .head_priority   (head_priority),
    .queue_empty     (queue_empty),
    .stored_count    (stored_count)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stable priority queue
// ----------------------------------------------------------------------------
// A short table of directed pushes and pops runs first: pop after reset,
// extreme values and priorities, ties, a fill to capacity, and a push
// refused while full. Some rows carry a typed-in expected result. After that
// come random phases with varied mixes of pushes and pops, so the queue
// fills and drains again and again. Every accepted item goes through a
// behavioral model of the sorted store, and each result transfer is checked
// field by field against the oldest expected result. Both channels idle
// and stall at random, with calm phases in which neither side does.
// ----------------------------------------------------------------------------
module tb_top;

  // item kinds
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam int DIRECTED_ROWS = 24;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS   = 50;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PRINT_LIMIT   = 20;

  // one result transfer, fields in port order
  typedef struct packed {
    logic [spq_pkg::VAL_W-1:0]  popped_value;
    logic [spq_pkg::PRI_W-1:0]  popped_priority;
    logic                       popped_valid;
    logic                       pop_on_empty;
    logic                       push_dropped;
    logic [spq_pkg::VAL_W-1:0]  head_value;
    logic [spq_pkg::PRI_W-1:0]  head_priority;
    logic                       queue_empty;
    logic [spq_pkg::OCNT_W-1:0] stored_count;
  } outcome_t;

  // one stimulus row; golden is used only when typed is set
  typedef struct packed {
    bit                        typed;
    logic                      kind;
    logic [spq_pkg::VAL_W-1:0] value;
    logic [spq_pkg::PRI_W-1:0] prio;
    outcome_t                  golden;
  } stim_row_t;

  localparam outcome_t NO_GOLDEN = '0;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  logic                       kind = OP_PUSH;
  logic [spq_pkg::VAL_W-1:0]  item_value = '0;
  logic [spq_pkg::PRI_W-1:0]  item_priority = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [spq_pkg::VAL_W-1:0]  popped_value;
  logic [spq_pkg::PRI_W-1:0]  popped_priority;
  logic                       popped_valid;
  logic                       pop_on_empty;
  logic                       push_dropped;
  logic [spq_pkg::VAL_W-1:0]  head_value;
  logic [spq_pkg::PRI_W-1:0]  head_priority;
  logic                       queue_empty;
  logic [spq_pkg::OCNT_W-1:0] stored_count;

  // travels with the payload so the monitor knows whether a typed result applies
  bit                row_typed = 1'b0;
  outcome_t          row_golden = '0;

  // when set, neither side idles or stalls
  bit                calm = 1'b0;

  stable_priority_queue dut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .kind            (kind),
    .item_value      (item_value),
    .item_priority   (item_priority),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .popped_value    (popped_value),
    .popped_priority (popped_priority),
    .popped_valid    (popped_valid),
    .pop_on_empty    (pop_on_empty),
    .push_dropped    (push_dropped),
    .head_value      (head_value),
    .head_priority   (head_priority),
    .queue_empty     (queue_empty),
    .stored_count    (stored_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // behavioral model of the sorted store
  // --------------------------------------------------------------------------
  logic [spq_pkg::VAL_W-1:0] model_values [spq_pkg::CAPACITY];
  logic [spq_pkg::PRI_W-1:0] model_prios  [spq_pkg::CAPACITY];
  int               model_fill = 0;
  int               peak_fill = 0;

  outcome_t         pending_outcomes [$];
  int               mismatch_count = 0;
  int               results_checked = 0;
  int               pushes_taken = 0;
  int               pops_taken = 0;
  int               drops_seen = 0;
  int               empty_pops_seen = 0;

  // applies one push or pop to the model and returns the result it should give
  function automatic outcome_t advance_queue(logic op, logic [spq_pkg::VAL_W-1:0] val,
                                             logic [spq_pkg::PRI_W-1:0] pri);
    outcome_t o;
    int       pos;
    o = '0;
    if (op == OP_PUSH) begin
      if (model_fill >= spq_pkg::CAPACITY) begin
        o.push_dropped = 1'b1;
      end else begin
        // new entry goes behind everything of equal or higher priority
        pos = 0;
        while (pos < model_fill && model_prios[pos] >= pri) pos++;
        for (int i = model_fill; i > pos; i--) begin
          model_values[i] = model_values[i-1];
          model_prios[i]  = model_prios[i-1];
        end
        model_values[pos] = val;
        model_prios[pos]  = pri;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        o.pop_on_empty = 1'b1;
      end else begin
        o.popped_value    = model_values[0];
        o.popped_priority = model_prios[0];
        o.popped_valid    = 1'b1;
        for (int i = 1; i < model_fill; i++) begin
          model_values[i-1] = model_values[i];
          model_prios[i-1]  = model_prios[i];
        end
        model_fill--;
      end
    end
    if (model_fill > 0) begin
      o.head_value    = model_values[0];
      o.head_priority = model_prios[0];
    end else begin
      o.queue_empty = 1'b1;
    end
    o.stored_count = model_fill[spq_pkg::OCNT_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [spq_pkg::VAL_W-1:0] got,
                                 logic [spq_pkg::VAL_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] mismatch on result %0d, %s: got %h, expected %h",
               $time, results_checked, field, got, want);
  endtask

  task automatic check_outcome(outcome_t got, outcome_t want);
    if (got.popped_value !== want.popped_value)
      report_mismatch("popped_value", got.popped_value, want.popped_value);
    if (got.popped_priority !== want.popped_priority)
      report_mismatch("popped_priority", got.popped_priority, want.popped_priority);
    if (got.popped_valid !== want.popped_valid)
      report_mismatch("popped_valid", got.popped_valid, want.popped_valid);
    if (got.pop_on_empty !== want.pop_on_empty)
      report_mismatch("pop_on_empty", got.pop_on_empty, want.pop_on_empty);
    if (got.push_dropped !== want.push_dropped)
      report_mismatch("push_dropped", got.push_dropped, want.push_dropped);
    if (got.head_value !== want.head_value)
      report_mismatch("head_value", got.head_value, want.head_value);
    if (got.head_priority !== want.head_priority)
      report_mismatch("head_priority", got.head_priority, want.head_priority);
    if (got.queue_empty !== want.queue_empty)
      report_mismatch("queue_empty", got.queue_empty, want.queue_empty);
    if (got.stored_count !== want.stored_count)
      report_mismatch("stored_count", got.stored_count, want.stored_count);
  endtask

  // --------------------------------------------------------------------------
  // monitor: predict on every item transfer, check every result transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t predicted;
    outcome_t got;
    if (!rst) begin
      if (item_valid && !item_stall) begin
        predicted = advance_queue(kind, item_value, item_priority);
        // a typed-in row is trusted as written, the model still advances
        pending_outcomes.push_back(row_typed ? row_golden : predicted);
        if (kind == OP_PUSH) pushes_taken++;
        else pops_taken++;
        if (predicted.push_dropped) drops_seen++;
        if (predicted.pop_on_empty) empty_pops_seen++;
        if (model_fill > peak_fill) peak_fill = model_fill;
      end
      if (result_valid && !result_stall) begin
        got = '{popped_value, popped_priority, popped_valid, pop_on_empty,
                push_dropped, head_value, head_priority, queue_empty,
                stored_count};
        if (pending_outcomes.size() == 0) begin
          report_mismatch("unexpected result", got.head_value, '0);
        end else begin
          check_outcome(got, pending_outcomes.pop_front());
        end
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side back-pressure: mostly open, short bursts, a few long ones
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    int unsigned roll;
    if (rst || calm) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        result_stall <= 1'b0;
      end else if (roll < 92) begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(0, 2);
      end else begin
        result_stall <= 1'b1;
        stall_left   <= $urandom_range(8, 40);
      end
    end
  end

  // --------------------------------------------------------------------------
  // item side: optional idle gap, then hold the payload until the transfer
  // --------------------------------------------------------------------------
  task automatic drive_item(stim_row_t row);
    int unsigned roll;
    int          gap;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    kind          <= row.kind;
    item_value    <= row.value;
    item_priority <= row.prio;
    row_typed     <= row.typed;
    row_golden    <= row.golden;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // golden field order: popped value, popped priority, popped valid,
  // pop on empty, push dropped, head value, head priority, empty, count
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // pop straight after reset finds nothing
    '{1'b1, OP_POP,  16'h0000, 8'h00,
      '{16'h0000, 8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 8'h00, 1'b1, 5'd0}},
    // largest value and priority in and out again
    '{1'b1, OP_PUSH, 16'hFFFF, 8'hFF,
      '{16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 16'hFFFF, 8'hFF, 1'b0, 5'd1}},
    '{1'b1, OP_POP,  16'h0000, 8'h00,
      '{16'hFFFF, 8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b1, 5'd0}},
    // smallest value and priority
    '{1'b1, OP_PUSH, 16'h0000, 8'h00,
      '{16'h0000, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 8'h00, 1'b0, 5'd1}},
    // tie at the lowest priority lands behind the earlier entry
    '{1'b0, OP_PUSH, 16'h1234, 8'h00, NO_GOLDEN},
    // equal priorities keep arrival order
    '{1'b0, OP_PUSH, 16'h5555, 8'h80, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'hAAAA, 8'h80, NO_GOLDEN},
    // fill up to capacity, all below the head priority
    '{1'b0, OP_PUSH, 16'h8001, 8'h7F, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'h0001, 8'h01, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'h7FFE, 8'h7F, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'hC3C3, 8'h40, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'h3C3C, 8'h40, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'h0F0F, 8'h10, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'hF0F0, 8'h20, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'h0100, 8'h00, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'hFFFE, 8'h7E, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'h2468, 8'h02, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'h1357, 8'h01, NO_GOLDEN},
    '{1'b0, OP_PUSH, 16'h8000, 8'h7F, NO_GOLDEN},
    // push to a full queue is refused, contents unchanged
    '{1'b1, OP_PUSH, 16'hFFFF, 8'hFF,
      '{16'h0000, 8'h00, 1'b0, 1'b0, 1'b1, 16'h5555, 8'h80, 1'b0, 5'd16}},
    // pop from full exposes the tied entry behind it
    '{1'b1, OP_POP,  16'hFFFF, 8'hFF,
      '{16'h5555, 8'h80, 1'b1, 1'b0, 1'b0, 16'hAAAA, 8'h80, 1'b0, 5'd15}},
    '{1'b0, OP_POP,  16'h0000, 8'h00, NO_GOLDEN},
    // insert among the 0x7f group, then pop again
    '{1'b0, OP_PUSH, 16'h00FF, 8'h7F, NO_GOLDEN},
    '{1'b0, OP_POP,  16'h5A5A, 8'hA5, NO_GOLDEN}
  };

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t   row;
    int          push_pct;
    bit          tie_heavy;
    int          drain_wait;
    int unsigned roll;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) drive_item(directed_rows[r]);

    // phases alternate between filling (drops) and draining (empty pops)
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm <= (ph % 4 == 3);
      case (ph % 5)
        0:       push_pct = 85;
        1:       push_pct = 20;
        2:       push_pct = 50;
        3:       push_pct = 70;
        default: push_pct = 35;
      endcase
      tie_heavy = $urandom_range(0, 1);
      repeat (PHASE_ITEMS) begin
        row.typed  = 1'b0;
        row.golden = NO_GOLDEN;
        row.kind   = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        row.value  = spq_pkg::VAL_W'($urandom);
        roll = $urandom_range(0, 9);
        if (roll == 0) row.prio = '1;
        else if (roll == 1) row.prio = '0;
        else if (tie_heavy) row.prio = spq_pkg::PRI_W'($urandom_range(0, 3));
        else row.prio = spq_pkg::PRI_W'($urandom);
        drive_item(row);
      end
    end

    item_valid <= 1'b0;
    calm       <= 1'b0;

    drain_wait = 0;
    while (pending_outcomes.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    // leave room for any stray result
    repeat (8) @(posedge clk);
    if (pending_outcomes.size() != 0)
      report_mismatch("results never arrived",
                      spq_pkg::VAL_W'(pending_outcomes.size()), '0);

    $display("covered %0d pushes, %0d pops, %0d refused pushes, %0d pops on empty",
             pushes_taken, pops_taken, drops_seen, empty_pops_seen);
    $display("checked %0d results, deepest fill %0d of %0d, %0d mismatches",
             results_checked, peak_fill, spq_pkg::CAPACITY, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS stable_priority_queue");
    end else begin
      $display("FAIL stable_priority_queue");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAIL stable_priority_queue");
    $finish;
  end

endmodule
